// File: hdl/spp_pkg.sv
// Shared constants and types for the stride prefetch predictor.
package spp_pkg;
	localparam int HistoryDepth = 16;
	localparam int HistAw = $clog2(HistoryDepth);
	localparam int FillW = $clog2(HistoryDepth + 1);
	localparam int PageSize = 4096;
	localparam int PageBits = $clog2(PageSize);
	localparam int MaxLookahead = 16;
	localparam int LaW = 5;
	localparam int CntW = FillW;
	localparam logic [63:0] PAGE_STRIDE = 64'(PageSize);
	localparam logic [LaW-1:0] LA_RESET = LaW'(4);

	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_PREDICT = 1'b1;

	typedef struct packed {
		logic record;     // write address into ring
		logic start_sum;  // clear sum/count, start walk
		logic walk;       // read next entry and accumulate
		logic start_div;  // begin divider
		logic div_step;   // one quotient bit
		logic fin_stride; // sign fix and zero/empty handling
		logic emit;       // load output register with next prediction
	} spp_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic div_done;
		logic emit_last;
		logic out_free;
		logic none;
	} spp_sts_t;
endpackage

// File: hdl/spp_datapath.sv
// Datapath: history ring, delta accumulator, serial divider, output register.
module spp_datapath import spp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  spp_cmd_t        cmd,
	output spp_sts_t        sts,
	input  logic            in_mode,
	input  logic [63:0]     in_addr,
	input  logic            in_take,
	input  logic [LaW-1:0]  lookahead_q,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [63:0]     out_addr,
	output logic            out_last
);
	logic [63:0] mem_q [HistoryDepth];
	logic [FillW-1:0] fill_q;
	logic [HistAw-1:0] oldest_q;
	logic [63:0] cur_q, prev_q, sum_q, rd_q, stride_q, next_q, rem_q, quo_q;
	logic [CntW-1:0] cnt_q, k_q;
	logic [6:0] bit_q;
	logic [LaW-1:0] n_q, i_q;
	logic neg_q, have_prev_q, rd_ok_q, mode_q;
	logic [HistAw-1:0] rd_idx;
	logic [63:0] delta, mag_sum, rem_sh;
	logic [64:0] trial;

	assign rd_idx = oldest_q + k_q[HistAw-1:0];
	assign delta = rd_q - prev_q;
	assign mag_sum = sum_q[63] ? (64'd0 - sum_q) : sum_q;
	assign rem_sh = {rem_q[62:0], mag_sum[bit_q[5:0]]};
	assign trial = {1'b0, rem_sh} - {{(65-CntW){1'b0}}, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			oldest_q <= '0;
			out_valid <= 1'b0;
			rd_ok_q <= 1'b0;
		end else begin
			if (cmd.record) begin
				if (fill_q < FillW'(HistoryDepth)) fill_q <= fill_q + 1'b1;
				else oldest_q <= oldest_q + 1'b1;
			end
			rd_ok_q <= cmd.walk && (k_q < fill_q);
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.record) begin
			if (fill_q < FillW'(HistoryDepth))
				mem_q[oldest_q + fill_q[HistAw-1:0]] <= cur_q;
			else mem_q[oldest_q] <= cur_q;
		end
		rd_q <= mem_q[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cur_q <= in_addr;
			mode_q <= in_mode;
			n_q <= (lookahead_q > LaW'(MaxLookahead)) ? LaW'(MaxLookahead) : lookahead_q;
		end
		if (cmd.start_sum) begin
			sum_q <= '0; cnt_q <= '0; k_q <= '0; have_prev_q <= 1'b0;
		end
		if (cmd.walk && k_q < fill_q) k_q <= k_q + 1'b1;
		if (rd_ok_q) begin
			// accumulate page-multiple deltas
			prev_q <= rd_q;
			have_prev_q <= 1'b1;
			if (have_prev_q && delta[PageBits-1:0] == '0) begin
				sum_q <= sum_q + delta;
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (cmd.start_div) begin
			rem_q <= '0; quo_q <= '0; bit_q <= 7'd63; neg_q <= sum_q[63];
		end
		if (cmd.div_step) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0]; quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh; quo_q <= {quo_q[62:0], 1'b0};
			end
			bit_q <= bit_q - 1'b1;
		end
		if (cmd.fin_stride) begin
			if (fill_q < FillW'(2) || cnt_q == '0 || quo_q == '0) stride_q <= PAGE_STRIDE;
			else stride_q <= neg_q ? (64'd0 - quo_q) : quo_q;
			i_q <= '0;
			next_q <= cur_q;
		end
		if (cmd.emit) begin
			out_addr <= next_q + stride_q;
			next_q <= next_q + stride_q;
			out_last <= (i_q + 1'b1) == n_q;
			i_q <= i_q + 1'b1;
		end
	end

	// walk ends once every entry is read and the last one is folded in
	assign sts.walk_done = (k_q >= fill_q) && !rd_ok_q;
	assign sts.div_done = bit_q == 7'd0 || bit_q[6];
	assign sts.emit_last = (i_q + 1'b1) >= n_q;
	assign sts.out_free = !out_valid || out_ready;
	assign sts.none = (n_q == '0) || (mode_q == MODE_RECORD);
endmodule

// File: hdl/spp_ctrl.sv
// Controller state machine sequencing record, walk, divide and emit.
module spp_ctrl import spp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_take,
	input  logic     in_mode,
	input  spp_sts_t sts,
	output spp_cmd_t cmd,
	output logic     in_ready
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_REC = 6'b000010, S_WALK = 6'b000100,
		S_DIV = 6'b001000, S_FIN = 6'b010000, S_EMIT = 6'b100000
	} state_t;
	state_t state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_take) begin
					if (in_mode == MODE_RECORD) state_d = S_REC;
					else begin
						cmd.start_sum = 1'b1;
						state_d = S_WALK;
					end
				end
			end
			S_REC: begin
				cmd.record = 1'b1;
				state_d = S_IDLE;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					cmd.walk = 1'b0;
					cmd.start_div = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin_stride = 1'b1;
				state_d = sts.none ? S_IDLE : S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

// File: hdl/stride_prefetch_predictor_unit.sv
// Top level of the stride prefetch predictor.
//  channel  | dir | data
//  s_axis   | in  | tdata = address[63:0], tuser = mode
//  m_axis   | out | tdata = predicted_address[63:0], tlast = last
//  cfg      | in  | lookahead[4:0]
// Record: the address is written into the history ring. Predict: a walk over the history entries,
// the bit-serial divider and a fixup state, then one word per cycle
// while the output is taken. Input is held off until the last word is loaded.
// Reset clears fill and slot; lookahead resets to 4. A stalled output holds its word.
module stride_prefetch_predictor_unit import spp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata, // address
	input  logic        s_axis_tuser, // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata, // predicted_address
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);
	spp_cmd_t cmd;
	spp_sts_t sts;
	logic [LaW-1:0] lookahead_q;
	logic take;

	assign take = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lookahead_q <= LA_RESET;
		else if (cfg_we) lookahead_q <= cfg_wdata;
	end

	spp_ctrl u_ctrl (.clk, .arst_n, .in_take(take), .in_mode(s_axis_tuser),
		.sts, .cmd, .in_ready(s_axis_tready));

	spp_datapath u_dp (.clk, .arst_n, .cmd, .sts, .in_mode(s_axis_tuser),
		.in_addr(s_axis_tdata), .in_take(take), .lookahead_q,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_addr(m_axis_tdata), .out_last(m_axis_tlast));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed under stall");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !s_axis_tready)
		else $error("unexpected accept");
	a_rec_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		take && !s_axis_tuser |=> !cmd.emit)
		else $error("record produced output");
endmodule

// File: sim/stride_prefetch_predictor_unit_test.sv
// Self-checking test of the stride prefetch predictor: directed and random record/predict streams.
`timescale 1ns / 100ps

module stride_prefetch_predictor_unit_test;
	import spp_pkg::*;

	typedef struct packed {
		logic        mode;
		logic [63:0] addr;
	} page_req_t;

	typedef struct packed {
		logic [63:0] addr;
		logic        last;
	} prefetch_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;

	stride_prefetch_predictor_unit u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [63:0] ring [HistoryDepth];
	int unsigned ring_fill;
	int unsigned ring_head;
	logic [4:0]  la_reg;

	page_req_t   req_q [$];
	prefetch_t   prefetch_q [$];
	int          mismatches;
	int          n_words;
	int          n_pred;
	int          idle_cycles;
	bit          hold_send;
	int          burst_left;
	int          gap_left;
	int unsigned stall_pat;

	function automatic logic [63:0] mean_stride();
		logic [63:0] sum, d, mag, q;
		int unsigned cnt;
		sum = '0;
		cnt = 0;
		if (ring_fill < 2)
			return PAGE_STRIDE;
		for (int k = 1; k < ring_fill; k++) begin
			d = ring[(ring_head + k) % HistoryDepth] - ring[(ring_head + k - 1) % HistoryDepth];
			mag = d[63] ? -d : d;
			if (mag % PAGE_STRIDE == 0) begin
				sum += d;
				cnt++;
			end
		end
		if (cnt == 0)
			return PAGE_STRIDE;
		q = (sum[63] ? -sum : sum) / 64'(cnt);
		if (sum[63])
			q = -q;
		return (q == 0) ? PAGE_STRIDE : q;
	endfunction

	task automatic apply_request(input page_req_t r);
		logic [63:0] st;
		int n;
		prefetch_t p;
		if (r.mode == MODE_RECORD) begin
			if (ring_fill < HistoryDepth) begin
				ring[(ring_head + ring_fill) % HistoryDepth] = r.addr;
				ring_fill++;
			end else begin
				ring[ring_head] = r.addr;
				ring_head = (ring_head + 1) % HistoryDepth;
			end
			return;
		end
		n = (la_reg > MaxLookahead) ? MaxLookahead : la_reg;
		st = mean_stride();
		n_pred++;
		for (int i = 1; i <= n; i++) begin
			p.addr = r.addr + st * 64'(i);
			p.last = (i == n);
			prefetch_q = {prefetch_q, p};
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatches++;
		$display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
	endtask

	// driver: bursts with random gaps
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			apply_request({s_axis_tuser, s_axis_tdata});
		if (!(s_axis_tvalid && !s_axis_tready)) begin
			if (gap_left > 0 || hold_send || req_q.size() == 0 || !arst_n) begin
				s_axis_tvalid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				page_req_t r;
				r = req_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= r.mode;
				s_axis_tdata <= r.addr;
				if (burst_left > 0)
					burst_left--;
				else begin
					burst_left = $urandom_range(12);
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(30);
				end
			end
		end
	end

	// monitor and output stall pattern
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			n_words++;
			if (prefetch_q.size() == 0)
				report("unexpected word", m_axis_tdata, '0);
			else begin
				prefetch_t e;
				e = prefetch_q.pop_front();
				if (m_axis_tdata !== e.addr)
					report("predicted_address", m_axis_tdata, e.addr);
				if (m_axis_tlast !== e.last)
					report("last", 64'(m_axis_tlast), 64'(e.last));
			end
		end
		stall_pat = {stall_pat[30:0], stall_pat[31] ^ stall_pat[21] ^ stall_pat[1] ^ stall_pat[0]};
		m_axis_tready <= (n_words / 64) % 3 == 0 ? 1'b1 : stall_pat[0] | stall_pat[3];
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > 5000) begin
			$display("Timeout: no word moved for 5000 cycles");
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		while (req_q.size() != 0 || s_axis_tvalid || prefetch_q.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic set_lookahead(input logic [4:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		la_reg = v;
	endtask

	task automatic push(input logic mode, input logic [63:0] a);
		page_req_t r;
		r.mode = mode;
		r.addr = a;
		req_q = {req_q, r};
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_phase(input int items);
		logic [63:0] base, step;
		int run;
		for (int i = 0; i < items; ) begin
			case ($urandom_range(3))
				0, 1: begin
					// strided run followed by a predict
					base = rnd64();
					step = 64'($signed($urandom_range(16)) - 8) * PAGE_STRIDE;
					if ($urandom_range(4) == 0)
						step = rnd64() & ~64'(PageSize - 1);
					run = $urandom_range(2, 18);
					for (int k = 0; k < run; k++) begin
						push(MODE_RECORD, base + step * 64'(k) +
							(($urandom_range(7) == 0) ? 64'($urandom_range(4095)) : 64'd0));
						i++;
					end
					push(MODE_PREDICT, rnd64());
					i++;
				end
				2: begin
					push(MODE_RECORD, rnd64());
					i++;
				end
				default: begin
					push(MODE_PREDICT, rnd64());
					i++;
				end
			endcase
		end
	endtask

	initial begin
		mismatches = 0;
		n_words = 0;
		n_pred = 0;
		idle_cycles = 0;
		hold_send = 0;
		burst_left = 0;
		gap_left = 0;
		stall_pat = 32'h1;
		ring_fill = 0;
		ring_head = 0;
		la_reg = LA_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty and single-entry history, then extremes
		push(MODE_PREDICT, '1);
		push(MODE_RECORD, 64'h0);
		push(MODE_PREDICT, 64'h0);
		push(MODE_RECORD, 64'hFFFF_FFFF_FFFF_F000);
		push(MODE_PREDICT, 64'h8000_0000_0000_0000);
		push(MODE_RECORD, 64'h0000_0000_0000_0123);
		push(MODE_PREDICT, 64'h7FFF_FFFF_FFFF_FFFF);
		// equal addresses: mean of zero
		for (int k = 0; k < 17; k++)
			push(MODE_RECORD, 64'h5000);
		push(MODE_PREDICT, 64'h1234);
		wait_drained();

		set_lookahead(5'd0);
		push(MODE_PREDICT, 64'hAAAA_5555_AAAA_5555);
		push(MODE_RECORD, 64'h9000);
		set_lookahead(5'd31);
		push(MODE_PREDICT, 64'h5555_AAAA_5555_AAAA);
		set_lookahead(5'd16);
		random_phase(70);

		// let every expected word arrive before sending more
		wait (req_q.size() == 0 && !s_axis_tvalid);
		hold_send = 1;
		while (prefetch_q.size() != 0)
			@(posedge clk);
		hold_send = 0;

		set_lookahead(5'd1);
		random_phase(60);
		set_lookahead(5'd17);
		random_phase(50);
		set_lookahead(5'd0);
		random_phase(10);
		set_lookahead(5'd7);
		random_phase(40);
		wait_drained();

		$display("Covered %0d prediction requests and %0d prefetch words", n_pred, n_words);
		$display("across lookahead settings 0, 1, 4, 7, 16, 17 and 31.");
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: filelist.f
hdl/spp_pkg.sv
hdl/spp_datapath.sv
hdl/spp_ctrl.sv
hdl/stride_prefetch_predictor_unit.sv
sim/stride_prefetch_predictor_unit_test.sv
